@@ design/zip_traditional_stream_decrypt_macros.svh @@
// assertion macros for the zip traditional stream decryptor
`ifndef ZIP_TRADITIONAL_STREAM_DECRYPT_MACROS_SVH
`define ZIP_TRADITIONAL_STREAM_DECRYPT_MACROS_SVH

`ifndef ASSERT_OFF
`define ZTSD_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error("ztsd assertion failed");
`define ZTSD_ASSERT_NR(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) \
		else $error("ztsd assertion failed");
`else
`define ZTSD_ASSERT(lbl, clk_s, rst_n_s, prop)
`define ZTSD_ASSERT_NR(lbl, clk_s, prop)
`endif

`endif

@@ design/ztsd_pkg.sv @@
`timescale 1ns / 1ps
package ztsd_pkg;

	localparam logic [31:0] KEY0_INIT = 32'h12345678;
	localparam logic [31:0] KEY1_INIT = 32'h23456789;
	localparam logic [31:0] KEY2_INIT = 32'h34567890;
	localparam logic [31:0] LCG_MULT  = 32'd134775813;
	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;

	localparam int unsigned HEADER_BYTES_DEF = 12;
	localparam int unsigned HC_W = 4;

	localparam logic [2:0] M_RESET = 3'd0;
	localparam logic [2:0] M_PASS  = 3'd1;
	localparam logic [2:0] M_START = 3'd2;
	localparam logic [2:0] M_DEC   = 3'd3;
	localparam logic [2:0] M_HDR   = 3'd4;

	typedef logic [31:0] crc_lut_t [256];

	typedef struct packed {
		logic accept;
		logic crc0;
		logic mul;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic            key_mode_in;
		logic [HC_W-1:0] hdr_count;
	} sts_t;

	function automatic crc_lut_t gen_crc_lut();
		crc_lut_t tbl;
		logic [31:0] v;
		for (int i = 0; i < 256; i++) begin
			v = 32'(i);
			for (int k = 0; k < 8; k++) begin
				v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
			end
			tbl[i] = v;
		end
		return tbl;
	endfunction

	localparam crc_lut_t CRC_LUT = gen_crc_lut();

	// one crc-32 byte step through the table
	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		return (crc >> 8) ^ CRC_LUT[crc[7:0] ^ b];
	endfunction

	function automatic logic [7:0] keystream(input logic [15:0] k);
		logic [15:0] t;
		logic [31:0] p;
		t = k | 16'd2;
		p = 32'(t) * 32'(t ^ 16'd1);
		return p[15:8];
	endfunction

endpackage

@@ design/ztsd_ctrl.sv @@
`timescale 1ns / 1ps
module ztsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ztsd_pkg::sts_t    sts,
	output ztsd_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CRC0 = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free  = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;

	assign cmd.accept = (state_q == ST_IDLE) && in_valid;
	assign cmd.crc0   = (state_q == ST_CRC0);
	assign cmd.mul    = (state_q == ST_MUL);
	assign cmd.finish = (state_q == ST_FIN) && slot_free;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = sts.key_mode_in ? ST_CRC0 : ST_FIN;
				end
			end
			ST_CRC0: state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_FIN;
			ST_FIN: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/ztsd_dp.sv @@
`timescale 1ns / 1ps
module ztsd_dp #(
	parameter int unsigned HEADER_BYTES = ztsd_pkg::HEADER_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     mode,
	input  logic [7:0]     data_byte,
	input  logic [7:0]     check_value,
	input  ztsd_pkg::cmd_t cmd,
	output ztsd_pkg::sts_t sts,
	output logic [7:0]     plain_byte,
	output logic           header_done,
	output logic           header_ok
);

	localparam logic [ztsd_pkg::HC_W-1:0] HDR_LAST = ztsd_pkg::HC_W'(HEADER_BYTES);

	logic [2:0][31:0]            saved_q;
	logic [2:0][31:0]            working_q;
	logic [2:0][31:0]            src;
	logic [2:0][31:0]            new_keys;
	logic [ztsd_pkg::HC_W-1:0]   hc_q;
	logic [ztsd_pkg::HC_W-1:0]   hc_inc;
	logic                        hdr_end;
	logic [2:0]                  mode_q;
	logic [7:0]                  check_q;
	logic [7:0]                  b_q;
	logic [7:0]                  ks;
	logic [31:0]                 k0n;
	logic [31:0]                 k0n_q;
	logic [31:0]                 sum_q;
	logic [31:0]                 prod;
	logic [31:0]                 k1n_q;
	logic [31:0]                 k2n;
	logic [7:0]                  plain_q;
	logic                        done_q;
	logic                        ok_q;

	assign sts.key_mode_in = (mode inside {ztsd_pkg::M_PASS, ztsd_pkg::M_DEC, ztsd_pkg::M_HDR});
	assign sts.hdr_count   = hc_q;

	// password bytes advance the saved set, data bytes the working set
	assign src      = (mode_q == ztsd_pkg::M_PASS) ? saved_q : working_q;
	assign ks       = ztsd_pkg::keystream(working_q[2][15:0]);
	assign k0n      = ztsd_pkg::crc_step(src[0], b_q);
	assign prod     = sum_q * ztsd_pkg::LCG_MULT;
	assign k2n      = ztsd_pkg::crc_step(src[2], k1n_q[31:24]);
	assign new_keys = {k2n, k1n_q, k0n_q};
	assign hc_inc   = hc_q + ztsd_pkg::HC_W'(1);
	assign hdr_end  = (hc_inc >= HDR_LAST);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q  <= mode;
			check_q <= check_value;
			b_q     <= (mode inside {ztsd_pkg::M_DEC, ztsd_pkg::M_HDR}) ?
			           (data_byte ^ ks) : data_byte;
		end
		if (cmd.crc0) begin
			k0n_q <= k0n;
			sum_q <= src[1] + {24'd0, k0n[7:0]};
		end
		if (cmd.mul) begin
			k1n_q <= prod + 32'd1;
		end
		if (cmd.finish) begin
			plain_q <= 8'd0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			case (mode_q)
				ztsd_pkg::M_DEC: plain_q <= b_q;
				ztsd_pkg::M_HDR: begin
					plain_q <= b_q;
					done_q  <= hdr_end;
					ok_q    <= hdr_end && (b_q == check_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saved_q   <= {ztsd_pkg::KEY2_INIT, ztsd_pkg::KEY1_INIT, ztsd_pkg::KEY0_INIT};
			working_q <= {ztsd_pkg::KEY2_INIT, ztsd_pkg::KEY1_INIT, ztsd_pkg::KEY0_INIT};
			hc_q      <= '0;
		end else if (cmd.finish) begin
			case (mode_q)
				ztsd_pkg::M_RESET: begin
					saved_q   <= {ztsd_pkg::KEY2_INIT, ztsd_pkg::KEY1_INIT,
					              ztsd_pkg::KEY0_INIT};
					working_q <= {ztsd_pkg::KEY2_INIT, ztsd_pkg::KEY1_INIT,
					              ztsd_pkg::KEY0_INIT};
					hc_q      <= '0;
				end
				ztsd_pkg::M_PASS: saved_q <= new_keys;
				ztsd_pkg::M_START: begin
					working_q <= saved_q;
					hc_q      <= '0;
				end
				ztsd_pkg::M_DEC: working_q <= new_keys;
				ztsd_pkg::M_HDR: begin
					working_q <= new_keys;
					hc_q      <= hdr_end ? '0 : hc_inc;
				end
				default: ;
			endcase
		end
	end

	assign plain_byte  = plain_q;
	assign header_done = done_q;
	assign header_ok   = ok_q;

endmodule

@@ design/zip_traditional_stream_decrypt.sv @@
// channel  signals                             direction
// in       in_valid in_stall mode data_byte    item in
//          check_value
// out      out_valid out_stall plain_byte      item out
//          header_done header_ok
//
// password, decrypt and header items pass states crc0, mul and fin before
// the next accept: a crc table step, the 32-bit key multiply, a second
// crc step; other modes go straight to fin; one item is in work at a time
// reset loads the three initial key constants into both key sets
// a result waits in the output register while out_stall is high; the next
// item is taken meanwhile and holds in its last step until the slot frees
`timescale 1ns / 1ps
`include "zip_traditional_stream_decrypt_macros.svh"
module zip_traditional_stream_decrypt #(
	parameter int unsigned HEADER_BYTES = ztsd_pkg::HEADER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] mode,
	input  logic [7:0] data_byte,
	input  logic [7:0] check_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] plain_byte,
	output logic       header_done,
	output logic       header_ok
);

	ztsd_pkg::cmd_t cmd;
	ztsd_pkg::sts_t sts;

	ztsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ztsd_dp #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.data_byte   (data_byte),
		.check_value (check_value),
		.cmd         (cmd),
		.sts         (sts),
		.plain_byte  (plain_byte),
		.header_done (header_done),
		.header_ok   (header_ok)
	);

	`ZTSD_ASSERT(a_busy_after_accept, clk, arst_n, (in_valid && !in_stall) |=> in_stall)
	`ZTSD_ASSERT(a_ok_needs_done, clk, arst_n, (out_valid && header_ok) |-> header_done)
	`ZTSD_ASSERT(a_hc_range, clk, arst_n, sts.hdr_count <= ztsd_pkg::HC_W'(HEADER_BYTES - 1))

endmodule

@@ tb/zip_traditional_stream_decrypt_tb.sv @@
`timescale 1ns / 1ps
module zip_traditional_stream_decrypt_tb;
	import ztsd_pkg::*;

	localparam int unsigned HDR_LEN = HEADER_BYTES_DEF;
	localparam int unsigned ITEM_TARGET = 1400;
	localparam logic [2:0] M_SPARE_LO  = 3'd5;
	localparam logic [2:0] M_SPARE_MID = 3'd6;
	localparam logic [2:0] M_SPARE_HI  = 3'd7;

	typedef logic [31:0] key_set_t [3];

	typedef struct packed {
		logic [7:0] plain;
		logic       done;
		logic       ok;
	} plain_out_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] mode = M_RESET;
	logic [7:0] data_byte = 8'h00;
	logic [7:0] check_value = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] plain_byte;
	logic       header_done;
	logic       header_ok;

	key_set_t   pw_keys;
	key_set_t   run_keys;
	logic [3:0] hdr_seen;
	plain_out_t plain_owed [$];
	int         fail_count = 0;
	int         items_sent = 0;
	bit         quiet = 1'b0;

	zip_traditional_stream_decrypt #(
		.HEADER_BYTES(HDR_LEN)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.data_byte  (data_byte),
		.check_value(check_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.plain_byte (plain_byte),
		.header_done(header_done),
		.header_ok  (header_ok)
	);

	always #6 clk = ~clk;

	function automatic key_set_t fresh_keys();
		key_set_t k;
		k[0] = KEY0_INIT;
		k[1] = KEY1_INIT;
		k[2] = KEY2_INIT;
		return k;
	endfunction

	// bitwise reflected crc-32 over one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] v;
		v = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (v[0])
				v = (v >> 1) ^ CRC_POLY;
			else
				v = v >> 1;
		end
		return v;
	endfunction

	function automatic key_set_t roll_keys(input key_set_t k, input logic [7:0] b);
		key_set_t n;
		n[0] = crc32_byte(k[0], b);
		n[1] = (k[1] + {24'd0, n[0][7:0]}) * LCG_MULT + 32'd1;
		n[2] = crc32_byte(k[2], n[1][31:24]);
		return n;
	endfunction

	function automatic logic [7:0] stream_byte(input logic [31:0] k2);
		logic [15:0] t;
		logic [31:0] sq;
		t = k2[15:0] | 16'h0002;
		sq = 32'(t) * 32'(t ^ 16'h0001);
		return sq[15:8];
	endfunction

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic decrypt_model(input logic [2:0] m, input logic [7:0] d, input logic [7:0] c);
		plain_out_t r;
		r = '0;
		case (m)
			M_RESET: begin
				pw_keys = fresh_keys();
				run_keys = fresh_keys();
				hdr_seen = '0;
			end
			M_PASS: begin
				pw_keys = roll_keys(pw_keys, d);
			end
			M_START: begin
				run_keys = pw_keys;
				hdr_seen = '0;
			end
			M_DEC: begin
				r.plain = stream_byte(run_keys[2]) ^ d;
				run_keys = roll_keys(run_keys, r.plain);
			end
			M_HDR: begin
				r.plain = stream_byte(run_keys[2]) ^ d;
				run_keys = roll_keys(run_keys, r.plain);
				hdr_seen = hdr_seen + 4'd1;
				if (hdr_seen >= HDR_LEN) begin
					r.done = 1'b1;
					r.ok = (r.plain == c);
					hdr_seen = '0;
				end
			end
			default: begin
			end
		endcase
		plain_owed.push_back(r);
	endtask

	task automatic send_item(input logic [2:0] m, input logic [7:0] d, input logic [7:0] c);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		data_byte <= d;
		check_value <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		decrypt_model(m, d, c);
		if (m <= M_HDR)
			items_sent++;
	endtask

	task automatic send_header_byte(input bit match);
		logic [7:0] d;
		logic [7:0] c;
		d = 8'($urandom);
		c = 8'($urandom);
		if (match && hdr_seen == 4'(HDR_LEN - 1))
			c = stream_byte(run_keys[2]) ^ d;
		send_item(M_HDR, d, c);
	endtask

	task automatic wait_for_results();
		if (plain_owed.size() != 0) begin
			in_valid <= 1'b0;
			while (plain_owed.size() != 0)
				@(posedge clk);
		end
	endtask

	task automatic test_initial_keys();
		send_item(M_DEC, 8'h00, 8'h00);
		send_item(M_DEC, 8'hFF, 8'hFF);
	endtask

	task automatic test_unused_modes();
		send_item(M_SPARE_LO, 8'hFF, 8'hFF);
		send_item(M_SPARE_MID, 8'h00, 8'hFF);
		send_item(M_SPARE_HI, 8'hFF, 8'h00);
		send_item(M_DEC, 8'h5A, 8'h00);
	endtask

	task automatic test_password_header();
		send_item(M_RESET, 8'h00, 8'h00);
		send_item(M_PASS, 8'h00, 8'h00);
		send_item(M_PASS, 8'hFF, 8'hFF);
		send_item(M_START, 8'hFF, 8'hFF);
		send_item(M_HDR, 8'h00, 8'hFF);
		repeat (4) send_header_byte(1'b0);
		// decrypt in the middle of the header keeps the count
		send_item(M_DEC, 8'hFF, 8'h00);
		repeat (7) send_header_byte(1'b1);
	endtask

	task automatic test_key_reset();
		send_item(M_RESET, 8'hFF, 8'hFF);
		send_item(M_DEC, 8'hA5, 8'h00);
		wait_for_results();
	endtask

	task automatic test_random_sessions();
		int pw_len;
		int hdr_len;
		int dec_len;
		int stray_at;
		bit matched;
		while (items_sent < ITEM_TARGET) begin
			quiet = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					send_item(3'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				if ($urandom_range(0, 5) == 0)
					send_item(M_RESET, 8'($urandom), 8'($urandom));
				pw_len = $urandom_range(0, 8);
				repeat (pw_len) send_item(M_PASS, 8'($urandom), 8'($urandom));
				if ($urandom_range(0, 9) != 0)
					send_item(M_START, 8'($urandom), 8'($urandom));
				// mostly whole headers, a few cut short or running on past the wrap
				hdr_len = HDR_LEN;
				if ($urandom_range(0, 9) == 0)
					hdr_len = $urandom_range(1, 2 * HDR_LEN + 3);
				stray_at = -1;
				if ($urandom_range(0, 7) == 0)
					stray_at = $urandom_range(0, hdr_len - 1);
				matched = ($urandom_range(0, 3) != 0);
				for (int i = 0; i < hdr_len; i++) begin
					if (i == stray_at)
						send_item(M_DEC, 8'($urandom), 8'($urandom));
					send_header_byte(matched);
				end
				dec_len = $urandom_range(0, 12);
				if ($urandom_range(0, 9) == 0)
					dec_len = $urandom_range(20, 60);
				repeat (dec_len) send_item(M_DEC, 8'($urandom), 8'($urandom));
			end
			if ($urandom_range(0, 29) == 0)
				wait_for_results();
		end
		quiet = 1'b0;
	endtask

	initial begin
		int stall_left;
		plain_out_t want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (plain_owed.size() == 0) begin
					$error("result with nothing owed: plain_byte %0h", plain_byte);
					fail_count++;
				end else begin
					want = plain_owed.pop_front();
					if (plain_byte !== want.plain) begin
						$error("plain_byte expected %0h actual %0h", want.plain, plain_byte);
						fail_count++;
					end
					if (header_done !== want.done) begin
						$error("header_done expected %0b actual %0b", want.done, header_done);
						fail_count++;
					end
					if (header_ok !== want.ok) begin
						$error("header_ok expected %0b actual %0b", want.ok, header_ok);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = next_gap();
			end
		end
	end

	initial begin
		int wait_cycles;
		pw_keys = fresh_keys();
		run_keys = fresh_keys();
		hdr_seen = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_initial_keys();
		test_unused_modes();
		test_password_header();
		test_key_reset();
		test_random_sessions();
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (plain_owed.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (plain_owed.size() != 0) begin
			$error("%0d results never arrived", plain_owed.size());
			fail_count++;
		end
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/ztsd_pkg.sv
design/ztsd_ctrl.sv
design/ztsd_dp.sv
design/zip_traditional_stream_decrypt.sv
tb/zip_traditional_stream_decrypt_tb.sv
